// ===== rtl/i2c_to_spi_bridge_control_defines.svh =====
// Assertion macros shared by the bridge controller RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef I2C_TO_SPI_BRIDGE_CONTROL_DEFINES_SVH
`define I2C_TO_SPI_BRIDGE_CONTROL_DEFINES_SVH

// Check a property on every rising clock edge outside reset
`define I2SBC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define I2SBC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/i2sbc_pkg.sv =====
// Types and constants for the I2C to SPI bridge controller.
// No dependencies; imported by the controller, the top level and the bench.
`timescale 1ns / 1ps

package i2sbc_pkg;

   // I2C bus event carried by a request
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_STOP  = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   // Bridge operating mode
   typedef enum logic [1:0] {
      MODE_CMD   = 2'd0,
      MODE_SEND  = 2'd1,
      MODE_SETUP = 2'd2
   } mode_type;

   // Command bytes: select masks run from SEL_MIN up to below SEL_LIMIT
   localparam logic [7:0] SEL_MIN       = 8'h01;
   localparam logic [7:0] SEL_LIMIT     = 8'h0F;
   localparam logic [7:0] CMD_CONFIGURE = 8'hF0;
   localparam logic [3:0] SELECT_IDLE   = 4'hF;

   // One request as received
   typedef struct packed {
      op_type     op;
      logic [7:0] data_byte;
      logic [7:0] spi_return_byte;
   } item_type;

   // Result fields produced by the controller, except the store read data
   typedef struct packed {
      logic       spi_send_valid;
      logic [7:0] spi_send_byte;
      logic [3:0] chip_select_lines;
      logic       spi_bit_order;
      logic       spi_clock_polarity;
      logic       spi_clock_phase;
      logic       read_valid;
   } rsp_fields_type;

endpackage

// ===== rtl/i2sbc_store.sv =====
// Reply store: single write port, one registered read port.
// Depends on nothing beyond its parameter; used by the bridge top level.
`timescale 1ns / 1ps

module i2sbc_store #(
   parameter int STORE_DEPTH = 256,
   parameter int AW          = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [STORE_DEPTH];
   logic [7:0] rd_data_ff;

   // Write the returned byte
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register the read data; hold it until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/i2sbc_ctrl.sv =====
// Bridge mode state machine, chip selects, SPI mode bits and store positions.
// Depends on i2sbc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "i2c_to_spi_bridge_control_defines.svh"

module i2sbc_ctrl
   import i2sbc_pkg::*;
#(
   parameter int STORE_DEPTH = 256,
   parameter int AW          = 8,
   parameter int FW          = 9
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  item_type       item,
   output rsp_fields_type rsp,
   output logic           read_hit,
   output logic           wr_en,
   output logic [AW-1:0]  wr_addr,
   output logic [7:0]     wr_data,
   output logic           rd_en,
   output logic [AW-1:0]  rd_addr
);

   localparam logic [AW-1:0] LAST_POS = AW'(STORE_DEPTH - 1);
   localparam logic [FW-1:0] FULL     = FW'(STORE_DEPTH);

   mode_type      mode_ff, mode_in;
   logic [3:0]    select_ff, select_in;
   logic [2:0]    spi_mode_ff, spi_mode_in;
   logic [AW-1:0] wpos_ff, wpos_in;
   logic [AW-1:0] rpos_ff, rpos_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [AW-1:0] wpos_next, rpos_next;

   // Wrap positions at the end of the store
   assign wpos_next = (wpos_ff == LAST_POS) ? '0 : wpos_ff + AW'(1);
   assign rpos_next = (rpos_ff == LAST_POS) ? '0 : rpos_ff + AW'(1);

   // Next state
   always_comb begin
      mode_in     = mode_ff;
      select_in   = select_ff;
      spi_mode_in = spi_mode_ff;
      wpos_in     = wpos_ff;
      rpos_in     = rpos_ff;
      fill_in     = fill_ff;
      if (accept) begin
         unique case (item.op)
            OP_WRITE: begin
               unique case (mode_ff)
                  MODE_CMD: begin
                     if (item.data_byte >= SEL_MIN && item.data_byte < SEL_LIMIT) begin
                        select_in = select_ff & ~item.data_byte[3:0];
                        mode_in   = MODE_SEND;
                     end else if (item.data_byte == CMD_CONFIGURE) begin
                        mode_in = MODE_SETUP;
                     end
                  end
                  MODE_SEND: begin
                     wpos_in = wpos_next;
                     // Grow the written prefix when writing just past it
                     if (FW'(wpos_ff) == fill_ff) begin
                        fill_in = fill_ff + FW'(1);
                     end
                  end
                  MODE_SETUP: begin
                     spi_mode_in = {item.data_byte[5], item.data_byte[3], item.data_byte[2]};
                  end
                  default: begin
                  end
               endcase
            end
            OP_STOP: begin
               if (mode_ff == MODE_SEND) begin
                  select_in = SELECT_IDLE;
               end
               wpos_in = '0;
               mode_in = MODE_CMD;
            end
            OP_READ: begin
               rpos_in = rpos_next;
            end
            default: begin
            end
         endcase
      end
   end

   // Outputs for the current request
   always_comb begin
      rsp.spi_send_valid     = (item.op == OP_WRITE) && (mode_ff == MODE_SEND);
      rsp.spi_send_byte      = rsp.spi_send_valid ? item.data_byte : 8'h00;
      rsp.chip_select_lines  = select_in;
      rsp.spi_bit_order      = spi_mode_in[2];
      rsp.spi_clock_polarity = spi_mode_in[1];
      rsp.spi_clock_phase    = spi_mode_in[0];
      rsp.read_valid         = (item.op == OP_READ);
      read_hit               = (FW'(rpos_ff) < fill_ff);
      wr_en                  = accept && rsp.spi_send_valid;
      wr_addr                = wpos_ff;
      wr_data                = item.spi_return_byte;
      rd_en                  = accept && rsp.read_valid;
      rd_addr                = rpos_ff;
   end

   // Update state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_CMD;
         select_ff   <= SELECT_IDLE;
         spi_mode_ff <= '0;
         wpos_ff     <= '0;
         rpos_ff     <= '0;
         fill_ff     <= '0;
      end else begin
         mode_ff     <= mode_in;
         select_ff   <= select_in;
         spi_mode_ff <= spi_mode_in;
         wpos_ff     <= wpos_in;
         rpos_ff     <= rpos_in;
         fill_ff     <= fill_in;
      end
   end

   `I2SBC_ASSERT(a_fill_bound, clock, reset, fill_ff <= FULL, "fill count beyond store depth")
   `I2SBC_ASSERT(a_wpos_in_prefix, clock, reset, FW'(wpos_ff) <= fill_ff,
      "write position beyond written prefix")
   `I2SBC_ASSERT(a_select_mode, clock, reset,
      (select_ff != SELECT_IDLE) == (mode_ff == MODE_SEND),
      "chip selects low outside transmit mode")
   `I2SBC_ASSERT_IMPL(a_write_only_transmit, clock, reset, wr_en, mode_ff == MODE_SEND,
      "store written outside transmit mode")

endmodule

// ===== rtl/i2c_to_spi_bridge_control.sv =====
// Top level of the I2C to SPI bridge controller: request stage and result register.
// Depends on i2sbc_pkg, i2sbc_ctrl and i2sbc_store.
`timescale 1ns / 1ps
//
//   channel   direction   handshake             payload
//   req_      in          req_tvalid/tready     tuser: op; tdata: data, return byte
//   rsp_      out         rsp_tvalid/tready     tuser: valid flags; tdata: result
//
// One request is accepted per cycle while req_tready is high; its result is offered once the
// request stage with the registered store read, and then the result register, are loaded.
// Reset is synchronous; the store is not swept, a fill count over the
// written prefix makes never-written entries read as zero.
// A stalled result holds; one more request is still taken behind it.

module i2c_to_spi_bridge_control
   import i2sbc_pkg::*;
#(
   parameter int STORE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] operation
   input  logic [15:0] req_tdata,   // [7:0] data_byte, [15:8] spi_return_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // [0] spi_send_valid, [1] read_valid
   output logic [23:0] rsp_tdata    // [7:0] spi_send_byte, [11:8] chip_select_lines,
                                    // [12] spi_bit_order, [13] spi_clock_polarity,
                                    // [14] spi_clock_phase, [22:15] read_data, [23] zero
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int FW = $clog2(STORE_DEPTH + 1);

   item_type       item;
   logic           accept;
   rsp_fields_type ctrl_rsp;
   logic           ctrl_hit;
   logic           wr_en, rd_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   logic [7:0]     wr_data, rd_data;

   logic           s1_valid_ff, s1_valid_in;
   rsp_fields_type s1_rsp_ff;
   logic           s1_hit_ff;
   logic           s1_move;
   logic           out_valid_ff, out_valid_in;
   rsp_fields_type out_rsp_ff;
   logic [7:0]     out_read_ff;

   // Unpack the request
   assign item.op              = op_type'(req_tuser);
   assign item.data_byte       = req_tdata[7:0];
   assign item.spi_return_byte = req_tdata[15:8];

   // Advance the request stage when the result register frees up
   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign accept     = req_tvalid && req_tready;

   i2sbc_ctrl #(
      .STORE_DEPTH (STORE_DEPTH),
      .AW          (AW),
      .FW          (FW)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .item     (item),
      .rsp      (ctrl_rsp),
      .read_hit (ctrl_hit),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr)
   );

   i2sbc_store #(
      .STORE_DEPTH (STORE_DEPTH),
      .AW          (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Stage and result valid flags
   always_comb begin
      s1_valid_in = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      out_valid_in = s1_move ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the request stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_rsp_ff <= ctrl_rsp;
         s1_hit_ff <= ctrl_hit;
      end
   end

   // Load the result register; drop read data for unwritten entries
   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_rsp_ff  <= s1_rsp_ff;
         out_read_ff <= (s1_rsp_ff.read_valid && s1_hit_ff) ? rd_data : 8'h00;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = {out_rsp_ff.read_valid, out_rsp_ff.spi_send_valid};
   assign rsp_tdata  = {1'b0, out_read_ff, out_rsp_ff.spi_clock_phase,
                        out_rsp_ff.spi_clock_polarity, out_rsp_ff.spi_bit_order,
                        out_rsp_ff.chip_select_lines, out_rsp_ff.spi_send_byte};

endmodule

// ===== bench/i2c_to_spi_bridge_control_test.sv =====
// Self-checking bench for the I2C to SPI bridge controller: directed and random bus events
// with a bit-accurate predictor, random stalls on both channels and a long result hold-off.
// Depends on i2sbc_pkg and the i2c_to_spi_bridge_control RTL.
`timescale 1ns / 1ps

module i2c_to_spi_bridge_control_test;
   import i2sbc_pkg::*;

   localparam int         REPLY_DEPTH   = 256;
   localparam int         REQUEST_GOAL  = 1850;
   localparam int         LONG_HOLD     = 80;
   localparam logic [1:0] OP_UNUSED     = 2'd3;

   // Expected result of one request
   typedef struct packed {
      logic       send_valid;
      logic [7:0] send_byte;
      logic [3:0] select_lines;
      logic       bit_order;
      logic       clock_polarity;
      logic       clock_phase;
      logic       read_valid;
      logic [7:0] read_data;
   } bridge_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;   // [1:0] operation
   logic [15:0] req_tdata;   // [7:0] data_byte, [15:8] spi_return_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [1:0]  rsp_tuser;   // [0] spi_send_valid, [1] read_valid
   logic [23:0] rsp_tdata;   // [7:0] send byte, [11:8] selects, [12] order,
                             // [13] polarity, [14] phase, [22:15] read data

   // Predictor state
   mode_type    bridge_mode    = MODE_CMD;
   logic [3:0]  select_copy    = SELECT_IDLE;
   logic        order_copy     = 1'b0;
   logic        polarity_copy  = 1'b0;
   logic        phase_copy     = 1'b0;
   int          write_index    = 0;
   int          read_index     = 0;
   logic [7:0]  reply_copy [REPLY_DEPTH];

   bridge_result_type pending_results [$];

   // Stall controls and bookkeeping
   bit sender_idle_on   = 1'b1;
   bit receiver_idle_on = 1'b1;
   int long_hold_cycles = 0;
   int error_count      = 0;
   int requests_counted = 0;
   int spi_sends        = 0;
   int reads_served     = 0;
   int stops_seen       = 0;
   int config_writes    = 0;
   int results_checked  = 0;

   i2c_to_spi_bridge_control #(
      .STORE_DEPTH(REPLY_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advance the bridge state by one request and return what it should produce
   function automatic bridge_result_type predict_bridge(logic [1:0] op, logic [7:0] data_byte,
                                                        logic [7:0] return_byte);
      bridge_result_type r;
      r = '0;
      case (op)
         OP_WRITE: begin
            case (bridge_mode)
               MODE_CMD: begin
                  if (data_byte >= SEL_MIN && data_byte < SEL_LIMIT) begin
                     select_copy = select_copy & ~data_byte[3:0];
                     bridge_mode = MODE_SEND;
                     requests_counted++;
                  end else if (data_byte == CMD_CONFIGURE) begin
                     bridge_mode = MODE_SETUP;
                     requests_counted++;
                  end
               end
               MODE_SEND: begin
                  r.send_valid = 1'b1;
                  r.send_byte  = data_byte;
                  reply_copy[write_index] = return_byte;
                  write_index = (write_index + 1) % REPLY_DEPTH;
                  spi_sends++;
                  requests_counted++;
               end
               default: begin
                  order_copy    = data_byte[5];
                  polarity_copy = data_byte[3];
                  phase_copy    = data_byte[2];
                  config_writes++;
                  requests_counted++;
               end
            endcase
         end
         OP_STOP: begin
            if (bridge_mode == MODE_SEND)
               select_copy = SELECT_IDLE;
            write_index = 0;
            bridge_mode = MODE_CMD;
            stops_seen++;
            requests_counted++;
         end
         OP_READ: begin
            r.read_valid = 1'b1;
            r.read_data  = reply_copy[read_index];
            read_index   = (read_index + 1) % REPLY_DEPTH;
            reads_served++;
            requests_counted++;
         end
         default: ;
      endcase
      r.select_lines   = select_copy;
      r.bit_order      = order_copy;
      r.clock_polarity = polarity_copy;
      r.clock_phase    = phase_copy;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endtask

   // Compare each result against the oldest prediction, then record accepted requests
   always @(posedge clock) begin
      bridge_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("result arrived with no request outstanding");
               error_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("spi_send_valid", 8'(want.send_valid), 8'(rsp_tuser[0]));
               check_field("read_valid", 8'(want.read_valid), 8'(rsp_tuser[1]));
               check_field("spi_send_byte", want.send_byte, rsp_tdata[7:0]);
               check_field("chip_select_lines", 8'(want.select_lines), 8'(rsp_tdata[11:8]));
               check_field("spi_bit_order", 8'(want.bit_order), 8'(rsp_tdata[12]));
               check_field("spi_clock_polarity", 8'(want.clock_polarity), 8'(rsp_tdata[13]));
               check_field("spi_clock_phase", 8'(want.clock_phase), 8'(rsp_tdata[14]));
               check_field("read_data", want.read_data, rsp_tdata[22:15]);
               results_checked++;
            end
         end
         if (req_tvalid && req_tready)
            pending_results.push_back(predict_bridge(req_tuser, req_tdata[7:0],
                                                     req_tdata[15:8]));
      end
   end

   // Drain results, with a random or long hold-off before each one
   initial begin
      int gap;
      rsp_tready = 1'b0;
      forever begin
         if (long_hold_cycles > 0) begin
            gap = long_hold_cycles;
            long_hold_cycles = 0;
         end else begin
            gap = receiver_idle_on ? $urandom_range(0, 10) : 0;
         end
         @(negedge clock);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Offer one request after a random gap and hold it until accepted
   task automatic send_request(input logic [1:0] op, input logic [7:0] data_byte,
                               input logic [7:0] return_byte);
      int gap;
      gap = sender_idle_on ? $urandom_range(0, 10) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {return_byte, data_byte};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop offering and wait until every predicted result has been seen
   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Reads of the cleared store, ignored codes and stray command bytes
   task automatic test_idle_state();
      send_request(OP_READ, 8'h00, 8'h00);
      send_request(OP_READ, 8'hFF, 8'hFF);
      send_request(OP_UNUSED, 8'h01, 8'h55);
      send_request(OP_STOP, 8'h00, 8'h00);
      send_request(OP_WRITE, 8'h00, 8'hFF);
      send_request(OP_WRITE, SEL_LIMIT, 8'h00);
      send_request(OP_WRITE, 8'hFF, 8'h00);
      send_request(OP_WRITE, 8'hF1, 8'h00);
      wait_for_results();
   endtask

   // Select masks at both ends, data extremes, stop from transmit
   task automatic test_transmit();
      send_request(OP_WRITE, SEL_MIN, 8'h00);
      send_request(OP_WRITE, 8'h00, 8'hFF);
      send_request(OP_WRITE, 8'hFF, 8'h00);
      send_request(OP_UNUSED, 8'hAA, 8'h55);
      send_request(OP_STOP, 8'h00, 8'h00);
      send_request(OP_WRITE, SEL_LIMIT - 8'd1, 8'h00);
      send_request(OP_WRITE, 8'h5A, 8'hA5);
      send_request(OP_READ, 8'h00, 8'h00);
      send_request(OP_STOP, 8'h00, 8'h00);
      send_request(OP_READ, 8'h00, 8'h00);
      wait_for_results();
   endtask

   // Mode bits all set, then one at a time, stop from configure
   task automatic test_configure();
      send_request(OP_WRITE, CMD_CONFIGURE, 8'h00);
      send_request(OP_WRITE, 8'hFF, 8'h00);
      send_request(OP_WRITE, 8'h20, 8'h00);
      send_request(OP_WRITE, 8'h08, 8'h00);
      send_request(OP_WRITE, 8'h04, 8'h00);
      send_request(OP_READ, 8'h00, 8'h00);
      send_request(OP_STOP, 8'h00, 8'h00);
      wait_for_results();
   endtask

   // Run both store positions past the end of the store
   task automatic test_store_wrap();
      send_request(OP_WRITE, 8'($urandom_range(SEL_MIN, SEL_LIMIT - 1)), 8'($urandom));
      repeat (REPLY_DEPTH + 40) send_request(OP_WRITE, 8'($urandom), 8'($urandom));
      send_request(OP_STOP, 8'($urandom), 8'($urandom));
      repeat (REPLY_DEPTH + 40) send_request(OP_READ, 8'($urandom), 8'($urandom));
      wait_for_results();
   endtask

   // Hold results back while requests keep coming, so the input stalls
   task automatic test_backpressure();
      sender_idle_on   = 1'b0;
      long_hold_cycles = LONG_HOLD;
      send_request(OP_WRITE, 8'($urandom_range(SEL_MIN, SEL_LIMIT - 1)), 8'($urandom));
      repeat (30) begin
         if ($urandom_range(0, 3) == 0)
            send_request(OP_READ, 8'($urandom), 8'($urandom));
         else
            send_request(OP_WRITE, 8'($urandom), 8'($urandom));
      end
      send_request(OP_STOP, 8'($urandom), 8'($urandom));
      wait_for_results();
      sender_idle_on = 1'b1;
   endtask

   // Mostly well-formed sessions with random content, some broken ones and noise
   task automatic test_random_sessions();
      int kind;
      while (requests_counted < REQUEST_GOAL) begin
         sender_idle_on   = ($urandom_range(0, 3) != 0);
         receiver_idle_on = ($urandom_range(0, 3) != 0);
         kind = $urandom_range(0, 19);
         if (kind < 12) begin
            send_request(OP_WRITE, 8'($urandom_range(SEL_MIN, SEL_LIMIT - 1)), 8'($urandom));
            repeat ($urandom_range(1, 24)) begin
               if ($urandom_range(0, 4) == 0)
                  send_request(OP_READ, 8'($urandom), 8'($urandom));
               else
                  send_request(OP_WRITE, 8'($urandom), 8'($urandom));
            end
            // leave some sessions open so the next select byte goes out as data
            if ($urandom_range(0, 9) != 0)
               send_request(OP_STOP, 8'($urandom), 8'($urandom));
         end else if (kind < 16) begin
            send_request(OP_WRITE, CMD_CONFIGURE, 8'($urandom));
            repeat ($urandom_range(1, 3))
               send_request(OP_WRITE, 8'($urandom), 8'($urandom));
            send_request(OP_STOP, 8'($urandom), 8'($urandom));
         end else if (kind < 18) begin
            repeat ($urandom_range(1, 8)) send_request(OP_READ, 8'($urandom), 8'($urandom));
         end else begin
            repeat ($urandom_range(1, 6))
               send_request(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
         end
      end
      wait_for_results();
   endtask

   initial begin
      foreach (reply_copy[i]) reply_copy[i] = 8'h00;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = OP_WRITE;
      req_tdata  = 16'h0000;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_state();
      test_transmit();
      test_configure();
      test_store_wrap();
      test_backpressure();
      test_random_sessions();

      // let any stray result surface before the verdict
      repeat (8) @(posedge clock);
      $display("Checked %0d results from %0d effective requests: %0d SPI sends, %0d reads,",
               results_checked, requests_counted, spi_sends, reads_served);
      $display("%0d stops and %0d mode writes, with store wrap and a long output stall.",
               stops_seen, config_writes);
      if (error_count == 0 && pending_results.size() == 0)
         $display("i2c_to_spi_bridge_control verification clean");
      else
         $display("i2c_to_spi_bridge_control verification failed");
      $finish;
   end

   // Bound the run well beyond the slowest legal schedule
   initial begin
      #5_000_000;
      $display("i2c_to_spi_bridge_control verification failed");
      $finish;
   end

endmodule
